### hw/rtl/rotated_ellipse_column_rasterizer_defines.svh
// Assertion macros shared by the checker of the rotated ellipse column rasterizer.
`ifndef ROTATED_ELLIPSE_COLUMN_RASTERIZER_DEFINES_SVH
`define ROTATED_ELLIPSE_COLUMN_RASTERIZER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define REC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define REC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/rec_pkg.sv
// Types and constants of the rotated ellipse column rasterizer.
package rec_pkg;

   localparam int AXIS_W          = 6;
   localparam int ANGLE_W         = 16;
   localparam int CENTER_W        = 12;
   localparam int OFFSET_W        = 8;
   localparam int COORD_W         = 14;
   localparam int AREA_W          = 15;

   localparam int MAX_RADIUS      = 63;
   localparam int ANGLE_FRAC_BITS = 14;

   localparam int AXIS_MAX   = (1 << AXIS_W) - 1;
   localparam int CLAMP      = (MAX_RADIUS < AXIS_MAX) ? MAX_RADIUS : AXIS_MAX;
   localparam int MARGIN_W   = AXIS_W + 1;
   localparam int DY_W       = MARGIN_W + 1;
   localparam int PROD_W     = OFFSET_W + ANGLE_W;
   localparam int ACC_W      = PROD_W;
   localparam int SQ_W       = 2 * ACC_W - 2;
   localparam int AXSQ_W     = 2 * AXIS_W;
   localparam int TERM_W     = SQ_W + AXSQ_W;
   localparam int LHS_W      = TERM_W + 1;
   localparam int AB2_W      = 2 * AXSQ_W;
   localparam int LIMIT_W    = AB2_W + 2 * ANGLE_FRAC_BITS;
   localparam int CMP_W      = (LIMIT_W > LHS_W) ? LIMIT_W : LHS_W;
   localparam int LEN_W      = DY_W + 1;
   localparam int AREA_MAX   = (1 << AREA_W) - 1;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_SEMI_AXIS_A = 3'd0,
      REG_SEMI_AXIS_B = 3'd1,
      REG_COS_ANGLE   = 3'd2,
      REG_SIN_ANGLE   = 3'd3,
      REG_CENTER_COL  = 3'd4,
      REG_CENTER_ROW  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic        [AXIS_W-1:0]   semi_axis_a;
      logic        [AXIS_W-1:0]   semi_axis_b;
      logic signed [ANGLE_W-1:0]  cos_angle;
      logic signed [ANGLE_W-1:0]  sin_angle;
      logic        [CENTER_W-1:0] center_col;
      logic        [CENTER_W-1:0] center_row;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic setup_mul;
      logic setup_init;
      logic issue;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic pipe_empty;
      logic out_busy;
   } status_type;

endpackage

### hw/rtl/rec_if.sv
// Valid/ready channel interfaces for column requests and run results.
interface rec_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rec_pkg::OFFSET_W-1:0] col_offset;
   logic                                clear_area;

   modport source (output valid, output col_offset, output clear_area, input ready);
   modport sink (input valid, input col_offset, input clear_area, output ready);
endinterface

interface rec_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rec_pkg::COORD_W-1:0] column;
   logic                               run_found;
   logic signed [rec_pkg::COORD_W-1:0] run_start_row;
   logic signed [rec_pkg::COORD_W-1:0] run_end_row;
   logic        [rec_pkg::AREA_W-1:0]  area_total;

   modport source (output valid, output column, output run_found, output run_start_row,
                   output run_end_row, output area_total, input ready);
   modport sink (input valid, input column, input run_found, input run_start_row,
                 input run_end_row, input area_total, output ready);
endinterface

### hw/rtl/rec_csr.sv
// Configuration register file with an APB-style write and read port.
module rec_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rec_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rec_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rec_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output rec_pkg::cfg_type               cfg
);

   rec_pkg::cfg_type       cfg_ff;
   rec_pkg::cfg_type       cfg_in;
   rec_pkg::reg_index_type index;
   logic                   wr_en;

   assign index  = rec_pkg::reg_index_type'(paddr[rec_pkg::CSR_ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            rec_pkg::REG_SEMI_AXIS_A: cfg_in.semi_axis_a = pwdata[rec_pkg::AXIS_W-1:0];
            rec_pkg::REG_SEMI_AXIS_B: cfg_in.semi_axis_b = pwdata[rec_pkg::AXIS_W-1:0];
            rec_pkg::REG_COS_ANGLE:   cfg_in.cos_angle   = pwdata[rec_pkg::ANGLE_W-1:0];
            rec_pkg::REG_SIN_ANGLE:   cfg_in.sin_angle   = pwdata[rec_pkg::ANGLE_W-1:0];
            rec_pkg::REG_CENTER_COL:  cfg_in.center_col  = pwdata[rec_pkg::CENTER_W-1:0];
            rec_pkg::REG_CENTER_ROW:  cfg_in.center_row  = pwdata[rec_pkg::CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         rec_pkg::REG_SEMI_AXIS_A: prdata = rec_pkg::CSR_DATA_W'(cfg_ff.semi_axis_a);
         rec_pkg::REG_SEMI_AXIS_B: prdata = rec_pkg::CSR_DATA_W'(cfg_ff.semi_axis_b);
         rec_pkg::REG_COS_ANGLE:   prdata = rec_pkg::CSR_DATA_W'(cfg_ff.cos_angle);
         rec_pkg::REG_SIN_ANGLE:   prdata = rec_pkg::CSR_DATA_W'(cfg_ff.sin_angle);
         rec_pkg::REG_CENTER_COL:  prdata = rec_pkg::CSR_DATA_W'(cfg_ff.center_col);
         rec_pkg::REG_CENTER_ROW:  prdata = rec_pkg::CSR_DATA_W'(cfg_ff.center_row);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.semi_axis_a <= rec_pkg::AXIS_W'(1);
         cfg_ff.semi_axis_b <= rec_pkg::AXIS_W'(1);
         cfg_ff.cos_angle   <= rec_pkg::ANGLE_W'(1 << rec_pkg::ANGLE_FRAC_BITS);
         cfg_ff.sin_angle   <= '0;
         cfg_ff.center_col  <= '0;
         cfg_ff.center_row  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/rec_ctrl.sv
// Controller state machine that sequences setup, row scan, drain and result.
module rec_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rec_pkg::status_type status,
   output rec_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SETUP1 = 6'b000010,
      ST_SETUP2 = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready      = (state_ff == ST_IDLE);
   assign cmd.accept     = req_ready & req_valid;
   assign cmd.setup_mul  = (state_ff == ST_SETUP1);
   assign cmd.setup_init = (state_ff == ST_SETUP2);
   assign cmd.issue      = (state_ff == ST_SCAN);
   assign cmd.finish     = (state_ff == ST_RESULT) & ~status.out_busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SETUP1;
         end
         ST_SETUP1: state_in = ST_SETUP2;
         ST_SETUP2: state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.pipe_empty) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/rec_dp.sv
// Datapath: per-column setup, row accumulators, square-and-scale pipeline and run tracking.
module rec_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  rec_pkg::cmd_type                    cmd,
   input  rec_pkg::cfg_type                    cfg,
   input  logic signed [rec_pkg::OFFSET_W-1:0] col_offset,
   input  logic                                clear_area,
   input  logic                                rsp_ready,
   output rec_pkg::status_type                 status,
   output logic                                rsp_valid,
   output logic signed [rec_pkg::COORD_W-1:0]  column,
   output logic                                run_found,
   output logic signed [rec_pkg::COORD_W-1:0]  run_start_row,
   output logic signed [rec_pkg::COORD_W-1:0]  run_end_row,
   output logic        [rec_pkg::AREA_W-1:0]   area_total
);

   localparam int OFFSET_W = rec_pkg::OFFSET_W;
   localparam int COORD_W  = rec_pkg::COORD_W;
   localparam int AREA_W   = rec_pkg::AREA_W;
   localparam int AXIS_W   = rec_pkg::AXIS_W;
   localparam int MARGIN_W = rec_pkg::MARGIN_W;
   localparam int DY_W     = rec_pkg::DY_W;
   localparam int PROD_W   = rec_pkg::PROD_W;
   localparam int ACC_W    = rec_pkg::ACC_W;
   localparam int SQ_W     = rec_pkg::SQ_W;
   localparam int AXSQ_W   = rec_pkg::AXSQ_W;
   localparam int TERM_W   = rec_pkg::TERM_W;
   localparam int LHS_W    = rec_pkg::LHS_W;
   localparam int AB2_W    = rec_pkg::AB2_W;
   localparam int LIMIT_W  = rec_pkg::LIMIT_W;
   localparam int CMP_W    = rec_pkg::CMP_W;
   localparam int LEN_W    = rec_pkg::LEN_W;
   localparam int SHIFT    = 2 * rec_pkg::ANGLE_FRAC_BITS;
   localparam logic [AXIS_W-1:0] CLAMP_V = AXIS_W'(rec_pkg::CLAMP);
   localparam logic [AREA_W:0]   AREA_SAT = (AREA_W + 1)'(rec_pkg::AREA_MAX);

   // Column item and per-column constants.
   logic signed [OFFSET_W-1:0] dx_ff;
   logic                       clear_ff;
   logic signed [PROD_W-1:0]   pdxcos_ff, pdxcos_in;
   logic signed [PROD_W-1:0]   pdxsin_ff, pdxsin_in;
   logic signed [PROD_W-1:0]   pmcos_ff, pmcos_in;
   logic signed [PROD_W-1:0]   pmsin_ff, pmsin_in;
   logic        [MARGIN_W-1:0] margin_ff, margin_in;
   logic        [AXSQ_W-1:0]   a2_ff, a2_in;
   logic        [AXSQ_W-1:0]   b2_ff, b2_in;
   logic        [AB2_W-1:0]    ab2_ff, ab2_in;

   // Row accumulators.
   logic signed [ACC_W-1:0]    x_acc_ff, x_acc_in;
   logic signed [ACC_W-1:0]    y_acc_ff, y_acc_in;
   logic signed [DY_W-1:0]     dy_ff, dy_in;

   // Pipeline stages.
   logic                       s1_v_ff;
   logic signed [DY_W-1:0]     s1_dy_ff;
   logic        [SQ_W-1:0]     sqx_ff, sqx_in;
   logic        [SQ_W-1:0]     sqy_ff, sqy_in;
   logic                       s2_v_ff;
   logic signed [DY_W-1:0]     s2_dy_ff;
   logic        [TERM_W-1:0]   tx_ff, tx_in;
   logic        [TERM_W-1:0]   ty_ff, ty_in;

   // Run tracking and running area.
   logic                       found_ff, found_in;
   logic signed [DY_W-1:0]     first_ff, first_in;
   logic signed [DY_W-1:0]     last_ff, last_in;
   logic        [AREA_W-1:0]   area_ff, area_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0]  column_ff, column_in;
   logic                       found_out_ff;
   logic signed [COORD_W-1:0]  start_ff, start_in;
   logic signed [COORD_W-1:0]  end_ff, end_in;
   logic        [AREA_W-1:0]   area_out_ff;

   // Combinational helpers.
   logic        [AXIS_W-1:0]    a_clamped;
   logic signed [PROD_W-1:0]    dx_ext, cos_ext, sin_ext, margin_ext;
   logic        [DY_W-1:0]      margin_dy;
   logic signed [2*ACC_W-1:0]   x_wide, y_wide, sqx_full, sqy_full;
   logic        [TERM_W-1:0]    sqx_ext, sqy_ext, a2_ext, b2_ext;
   logic        [LHS_W-1:0]     lhs;
   logic        [LIMIT_W-1:0]   limit;
   logic                       row_hit;
   logic        [LEN_W-1:0]     run_len;
   logic        [AREA_W-1:0]   area_base;
   logic        [AREA_W:0]     area_sum;

   assign a_clamped  = (cfg.semi_axis_a < CLAMP_V) ? cfg.semi_axis_a : CLAMP_V;
   assign dx_ext     = PROD_W'(dx_ff);
   assign cos_ext    = PROD_W'(cfg.cos_angle);
   assign sin_ext    = PROD_W'(cfg.sin_angle);
   assign margin_ext = PROD_W'(margin_in);
   assign margin_dy  = DY_W'(margin_ff);

   always_comb begin
      margin_in = MARGIN_W'(a_clamped) + MARGIN_W'(2);
      pdxcos_in = dx_ext * cos_ext;
      pdxsin_in = dx_ext * sin_ext;
      pmcos_in  = margin_ext * cos_ext;
      pmsin_in  = margin_ext * sin_ext;
      a2_in     = AXSQ_W'(cfg.semi_axis_a) * AXSQ_W'(cfg.semi_axis_a);
      b2_in     = AXSQ_W'(cfg.semi_axis_b) * AXSQ_W'(cfg.semi_axis_b);
      ab2_in    = AB2_W'(a2_ff) * AB2_W'(b2_ff);
   end

   always_comb begin
      x_acc_in = x_acc_ff;
      y_acc_in = y_acc_ff;
      dy_in    = dy_ff;
      if (cmd.setup_init) begin
         x_acc_in = pdxcos_ff - pmsin_ff;
         y_acc_in = -pmcos_ff - pdxsin_ff;
         dy_in    = -$signed(margin_dy);
      end else if (cmd.issue) begin
         x_acc_in = x_acc_ff + sin_ext;
         y_acc_in = y_acc_ff + cos_ext;
         dy_in    = dy_ff + DY_W'(1);
      end
   end

   assign x_wide   = (2*ACC_W)'(x_acc_ff);
   assign y_wide   = (2*ACC_W)'(y_acc_ff);
   assign sqx_full = x_wide * x_wide;
   assign sqy_full = y_wide * y_wide;
   assign sqx_in   = sqx_full[SQ_W-1:0];
   assign sqy_in   = sqy_full[SQ_W-1:0];

   assign sqx_ext  = TERM_W'(sqx_ff);
   assign sqy_ext  = TERM_W'(sqy_ff);
   assign a2_ext   = TERM_W'(a2_ff);
   assign b2_ext   = TERM_W'(b2_ff);
   assign tx_in    = sqx_ext * b2_ext;
   assign ty_in    = sqy_ext * a2_ext;

   assign lhs      = LHS_W'(tx_ff) + LHS_W'(ty_ff);
   assign limit    = LIMIT_W'(ab2_ff) << SHIFT;
   assign row_hit  = s2_v_ff & (CMP_W'(lhs) < CMP_W'(limit));

   always_comb begin
      found_in = found_ff;
      first_in = first_ff;
      last_in  = last_ff;
      if (cmd.setup_init) begin
         found_in = 1'b0;
         first_in = '0;
         last_in  = '0;
      end else if (row_hit) begin
         found_in = 1'b1;
         last_in  = s2_dy_ff;
         if (!found_ff) first_in = s2_dy_ff;
      end
   end

   assign run_len   = LEN_W'(last_ff) - LEN_W'(first_ff) + LEN_W'(1);
   assign area_base = clear_ff ? '0 : area_ff;
   assign area_sum  = (AREA_W + 1)'(area_base) + (AREA_W + 1)'(run_len);

   always_comb begin
      area_in = area_ff;
      if (cmd.finish) begin
         if (!found_ff) begin
            area_in = area_base;
         end else if (area_sum > AREA_SAT) begin
            area_in = AREA_SAT[AREA_W-1:0];
         end else begin
            area_in = area_sum[AREA_W-1:0];
         end
      end
   end

   always_comb begin
      column_in = COORD_W'(cfg.center_col) + COORD_W'(dx_ff);
      start_in  = found_ff ? (COORD_W'(cfg.center_row) + COORD_W'(first_ff)) : '0;
      end_in    = found_ff ? (COORD_W'(cfg.center_row) + COORD_W'(last_ff)) : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.scan_last  = (dy_ff == $signed(margin_dy));
   assign status.pipe_empty = ~s1_v_ff & ~s2_v_ff;
   assign status.out_busy   = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign column        = column_ff;
   assign run_found     = found_out_ff;
   assign run_start_row = start_ff;
   assign run_end_row   = end_ff;
   assign area_total    = area_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         found_ff     <= 1'b0;
         area_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_v_ff      <= cmd.issue;
         s2_v_ff      <= s1_v_ff;
         found_ff     <= found_in;
         area_ff      <= area_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dx_ff    <= col_offset;
         clear_ff <= clear_area;
      end
      if (cmd.setup_mul) begin
         pdxcos_ff <= pdxcos_in;
         pdxsin_ff <= pdxsin_in;
         pmcos_ff  <= pmcos_in;
         pmsin_ff  <= pmsin_in;
         margin_ff <= margin_in;
         a2_ff     <= a2_in;
         b2_ff     <= b2_in;
      end
      if (cmd.setup_init) begin
         ab2_ff <= ab2_in;
      end
      x_acc_ff <= x_acc_in;
      y_acc_ff <= y_acc_in;
      dy_ff    <= dy_in;
      s1_dy_ff <= dy_ff;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      s2_dy_ff <= s1_dy_ff;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      if (cmd.finish) begin
         column_ff    <= column_in;
         found_out_ff <= found_ff;
         start_ff     <= start_in;
         end_ff       <= end_in;
         area_out_ff  <= area_in;
      end
   end

endmodule

### hw/rtl/rotated_ellipse_column_rasterizer.sv
// Top level of the rotated ellipse column rasterizer.
// An accepted request passes setup, a row scan over offsets -m to m (m = min(a, 63) + 2), drain and result.
// No new column is taken before the last result is registered; the row scan tests one row a cycle.
// The scan feeds the square and scale stages of the pipeline after the SETUP1 and SETUP2 states.
// Reset is synchronous: registers return to a=1, b=1, cos=1.0, sin=0, centers 0, area 0.
// A result transfer that waits on ready holds the next column in its result state.
module rotated_ellipse_column_rasterizer (
   input  logic                           clock,
   input  logic                           reset,
   rec_req_if.sink                        req_chan,
   rec_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rec_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rec_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rec_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   rec_pkg::cfg_type    cfg;
   rec_pkg::cmd_type    cmd;
   rec_pkg::status_type status;

   rec_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   rec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rec_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .col_offset    (req_chan.col_offset),
      .clear_area    (req_chan.clear_area),
      .rsp_ready     (rsp_chan.ready),
      .status        (status),
      .rsp_valid     (rsp_chan.valid),
      .column        (rsp_chan.column),
      .run_found     (rsp_chan.run_found),
      .run_start_row (rsp_chan.run_start_row),
      .run_end_row   (rsp_chan.run_end_row),
      .area_total    (rsp_chan.area_total)
   );

endmodule

### hw/rtl/rec_checker.sv
// Port-level assertion checker for the rotated ellipse column rasterizer and its bind.
`include "rotated_ellipse_column_rasterizer_defines.svh"

module rec_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [rec_pkg::COORD_W-1:0] rsp_column,
   input logic                               rsp_run_found,
   input logic signed [rec_pkg::COORD_W-1:0] rsp_run_start_row,
   input logic signed [rec_pkg::COORD_W-1:0] rsp_run_end_row,
   input logic        [rec_pkg::AREA_W-1:0]  rsp_area_total
);

   `REC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_column) && $stable(rsp_run_start_row) && $stable(rsp_area_total), "Stalled result transfer changed")

   `REC_ASSERT_NEXT(a_one_column, req_valid && req_ready, !req_ready, "Request taken while a column is in work")

   `REC_ASSERT_SAME(a_empty_run, rsp_valid && !rsp_run_found, rsp_run_start_row == 0 && rsp_run_end_row == 0, "Empty column reports nonzero rows")

   `REC_ASSERT_SAME(a_run_order, rsp_valid && rsp_run_found, rsp_run_end_row >= rsp_run_start_row, "Run ends before it starts")

endmodule

bind rotated_ellipse_column_rasterizer rec_checker u_rec_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_column        (rsp_chan.column),
   .rsp_run_found     (rsp_chan.run_found),
   .rsp_run_start_row (rsp_chan.run_start_row),
   .rsp_run_end_row   (rsp_chan.run_end_row),
   .rsp_area_total    (rsp_chan.area_total)
);
